// ----- rtl/olirf_pkg.sv -----
// ----------------------------------------------------------------------------
// olirf_pkg
// Shared types, widths and codes for the ordered list with insert, remove
// and find operations.
// ----------------------------------------------------------------------------
package olirf_pkg;

    // Number of entries the list can hold.
    localparam int CAPACITY = 64;

    // Field widths of the command and result beats.
    localparam int OP_W   = 2;
    localparam int ID_W   = 32;
    localparam int DUR_W  = 20;
    localparam int POS_W  = 16;
    localparam int ST_W   = 2;
    localparam int OUT_W  = 7;
    localparam int TOT_W  = 26;

    // Internal widths that follow from the capacity.
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = (DUR_W + CNT_W > TOT_W) ? (DUR_W + CNT_W) : TOT_W;

    // Largest reported total duration.
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NEG_POS   = 2'd3;

    // One command beat.
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [ID_W-1:0]  track_id;
        logic [DUR_W-1:0]        duration_seconds;
        logic signed [POS_W-1:0] position;
    } command_t;

    // One result beat.
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OUT_W-1:0] found_index;
        logic [DUR_W-1:0] found_duration;
        logic [OUT_W-1:0] entry_count;
        logic [TOT_W-1:0] total_duration;
    } result_t;

    // One stored list entry.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
    } entry_t;

    // Access request from the sequencer to the entry memory.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        entry_t            wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    // Completion of one operation, with the list totals after it.
    typedef struct packed {
        logic             valid;
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] idx;
        logic [DUR_W-1:0] fdur;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } finish_t;

endpackage

// ----- rtl/olirf_ram.sv -----
// ----------------------------------------------------------------------------
// olirf_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module olirf_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 52
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/olirf_seq.sv -----
// ----------------------------------------------------------------------------
// olirf_seq
// Operation sequencer: scans the entry memory for an id, shifts entries up
// or down one per cycle, and keeps the entry count and duration sum.
// ----------------------------------------------------------------------------
module olirf_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  olirf_pkg::command_t command,
    input  olirf_pkg::entry_t   rdata,
    output olirf_pkg::mem_req_t mem_req,
    output olirf_pkg::finish_t  fin,
    output logic                busy
);

    localparam int CNT_W = olirf_pkg::CNT_W;
    localparam int IDX_W = olirf_pkg::IDX_W;
    localparam int SUM_W = olirf_pkg::SUM_W;
    localparam int POS_W = olirf_pkg::POS_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DOWN = 3'd2;
    localparam logic [2:0] S_UP   = 3'd3;
    localparam logic [2:0] S_PUT  = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [CNT_W-1:0]               ptr_reg, ptr_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [olirf_pkg::DUR_W-1:0]    fdur_reg, fdur_next;
    logic [olirf_pkg::OP_W-1:0]     op_reg, op_next;
    logic [olirf_pkg::ID_W-1:0]     key_reg, key_next;
    logic [olirf_pkg::DUR_W-1:0]    dur_reg, dur_next;

    logic [POS_W-1:0] pos_u;
    logic [POS_W-1:0] count_wide;
    logic [CNT_W-1:0] ptr_inc1;
    logic [CNT_W-1:0] ptr_inc2;
    logic [CNT_W-1:0] ptr_dec1;
    logic [CNT_W-1:0] ptr_dec2;

    assign pos_u      = POS_W'(command.position);
    assign count_wide = POS_W'(count_reg);
    assign ptr_inc1   = ptr_reg + CNT_W'(1);
    assign ptr_inc2   = ptr_reg + CNT_W'(2);
    assign ptr_dec1   = ptr_reg - CNT_W'(1);
    assign ptr_dec2   = ptr_reg - CNT_W'(2);

    assign busy = (state_reg != S_IDLE);

    // Next-state, memory access and completion logic.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        fdur_next  = fdur_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        dur_next   = dur_reg;

        mem_req       = '0;
        mem_req.wdata = rdata;

        fin        = '0;
        fin.status = olirf_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = command.operation;
                    key_next = command.track_id;
                    dur_next = command.duration_seconds;
                    case (command.operation)
                        olirf_pkg::OP_INSERT:
                        begin
                            if (command.position[POS_W-1])
                            begin
                                fin.valid  = 1'b1;
                                fin.status = olirf_pkg::ST_NEG_POS;
                            end
                            else if (count_reg >= CNT_W'(olirf_pkg::CAPACITY))
                            begin
                                fin.valid  = 1'b1;
                                fin.status = olirf_pkg::ST_FULL;
                            end
                            else
                            begin
                                // Insert index is the position clamped to the count.
                                if (pos_u < count_wide)
                                begin
                                    idx_next = pos_u[CNT_W-1:0];
                                end
                                else
                                begin
                                    idx_next = count_reg;
                                end
                                ptr_next = count_reg;
                                if (idx_next == count_reg)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = IDX_W'(count_reg - CNT_W'(1));
                                    state_next    = S_UP;
                                end
                            end
                        end
                        olirf_pkg::OP_REMOVE, olirf_pkg::OP_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                fin.valid  = 1'b1;
                                fin.status = olirf_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                ptr_next      = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            fin.valid = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // The read data holds the entry at ptr_reg.
                if (rdata.id == key_reg)
                begin
                    idx_next  = ptr_reg;
                    fdur_next = rdata.dur;
                    if (op_reg == olirf_pkg::OP_REMOVE && ptr_inc1 < count_reg)
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = IDX_W'(ptr_inc1);
                        state_next    = S_DOWN;
                    end
                    else
                    begin
                        fin.valid  = 1'b1;
                        fin.idx    = ptr_reg;
                        fin.fdur   = rdata.dur;
                        state_next = S_IDLE;
                        if (op_reg == olirf_pkg::OP_REMOVE)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            sum_next   = sum_reg - SUM_W'(rdata.dur);
                        end
                    end
                end
                else if (ptr_inc1 < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(ptr_inc1);
                    ptr_next      = ptr_inc1;
                end
                else
                begin
                    fin.valid  = 1'b1;
                    fin.status = olirf_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end

            S_DOWN:
            begin
                // Move the entry above down into the gap.
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(ptr_reg);
                mem_req.wdata = rdata;
                if (ptr_inc2 < count_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(ptr_inc2);
                    ptr_next      = ptr_inc1;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    sum_next   = sum_reg - SUM_W'(fdur_reg);
                    fin.valid  = 1'b1;
                    fin.idx    = idx_reg;
                    fin.fdur   = fdur_reg;
                    state_next = S_IDLE;
                end
            end

            S_UP:
            begin
                // Move the entry below up by one place.
                mem_req.we    = 1'b1;
                mem_req.waddr = IDX_W'(ptr_reg);
                mem_req.wdata = rdata;
                ptr_next      = ptr_dec1;
                if (ptr_dec1 == idx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = IDX_W'(ptr_dec2);
                end
            end

            S_PUT:
            begin
                // Write the new entry into the opened slot.
                mem_req.we        = 1'b1;
                mem_req.waddr     = IDX_W'(idx_reg);
                mem_req.wdata.id  = key_reg;
                mem_req.wdata.dur = dur_reg;
                count_next        = count_reg + CNT_W'(1);
                sum_next          = sum_reg + SUM_W'(dur_reg);
                fin.valid         = 1'b1;
                fin.idx           = idx_reg;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fin.count = count_next;
        fin.sum   = sum_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        idx_reg  <= idx_next;
        fdur_reg <= fdur_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        dur_reg  <= dur_next;
    end

endmodule

// ----- rtl/ordered_list_insert_remove_find.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_find
// Bounded ordered list of (id, duration) entries held compactly in one
// synchronous memory, with insert at position, remove by id and find by id.
// ----------------------------------------------------------------------------
// Usage:
// A command beat is taken at a rising edge with start high and busy low.
// Each command gives exactly one result beat, shown on result for one cycle
// with done high; the receiver cannot stall it.
// Steps from the accepting edge to the result register:
//   rejected insert, unused code, find or remove on an empty list: the result
//   is formed in the idle state;
//   insert at index k: the entries from k up are moved up one place each,
//   then the new entry is written, then the result is registered;
//   find: a scan from index 0 up to the match or to the end of the list;
//   remove: scan to the match, then the entries above it are moved down one
//   by one through the memory's single write port.
// A new command may be taken in the cycle its predecessor's result is shown.
// Reset clears the entry count and the duration total; the entry memory is
// not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_find (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  olirf_pkg::command_t command,
    output logic                busy,
    output logic                done,
    output olirf_pkg::result_t  result
);

    olirf_pkg::mem_req_t mem_req;
    olirf_pkg::finish_t  fin;
    olirf_pkg::entry_t   rdata;
    olirf_pkg::result_t  result_reg, result_next;
    logic                done_reg;

    // Entry memory.
    olirf_ram #(
        .DEPTH (olirf_pkg::CAPACITY),
        .WIDTH ($bits(olirf_pkg::entry_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // Operation sequencer.
    olirf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .rdata   (rdata),
        .mem_req (mem_req),
        .fin     (fin),
        .busy    (busy)
    );

    // Format the result beat: narrow the counts and saturate the total.
    always_comb
    begin
        result_next.status         = fin.status;
        result_next.found_index    = olirf_pkg::OUT_W'(fin.idx);
        result_next.found_duration = fin.fdur;
        result_next.entry_count    = olirf_pkg::OUT_W'(fin.count);
        if (fin.sum > olirf_pkg::SUM_W'(olirf_pkg::TOTAL_MAX))
        begin
            result_next.total_duration = olirf_pkg::TOTAL_MAX;
        end
        else
        begin
            result_next.total_duration = olirf_pkg::TOT_W'(fin.sum);
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered list with insert, remove and find.
// Commands go in one beat at a time under the start/busy handshake. A track
// list model inside a small scoreboard predicts each result beat. Every done
// beat is compared field by field with the oldest prediction. A short
// directed run is followed by random phases that fill, drain and churn the
// list, with random gaps between command beats.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY = olirf_pkg::CAPACITY;
    localparam int OP_W     = olirf_pkg::OP_W;
    localparam int ID_W     = olirf_pkg::ID_W;
    localparam int DUR_W    = olirf_pkg::DUR_W;
    localparam int POS_W    = olirf_pkg::POS_W;
    localparam int OUT_W    = olirf_pkg::OUT_W;
    localparam int TOT_W    = olirf_pkg::TOT_W;

    // Operation code with no function in the block.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

    // Track list model and the queue of predicted result beats.
    class list_scoreboard;
        logic [ID_W-1:0]     ids [CAPACITY];
        logic [DUR_W-1:0]    durs [CAPACITY];
        int                  count;
        longint              sum;
        olirf_pkg::result_t  pending [$];
        int                  errors;

        function new();
            count  = 0;
            sum    = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Index of the first entry holding the key, or the count if none.
        function int locate(logic [ID_W-1:0] key);
            for (int i = 0; i < count; i++)
            begin
                if (ids[i] == key)
                    return i;
            end
            return count;
        endfunction

        // Apply one accepted command to the model and queue its result.
        function void note_command(olirf_pkg::command_t cmd);
            olirf_pkg::result_t r;
            int                 at;
            int                 pos;

            r   = '0;
            r.status = olirf_pkg::ST_OK;
            pos = int'(cmd.position);
            case (cmd.operation)
                olirf_pkg::OP_INSERT:
                begin
                    if (cmd.position[POS_W-1])
                        r.status = olirf_pkg::ST_NEG_POS;
                    else if (count >= CAPACITY)
                        r.status = olirf_pkg::ST_FULL;
                    else
                    begin
                        at = (pos < count) ? pos : count;
                        for (int i = count; i > at; i--)
                        begin
                            ids[i]  = ids[i-1];
                            durs[i] = durs[i-1];
                        end
                        ids[at]  = cmd.track_id;
                        durs[at] = cmd.duration_seconds;
                        count++;
                        sum += longint'(cmd.duration_seconds);
                        r.found_index = OUT_W'(at);
                    end
                end
                olirf_pkg::OP_REMOVE, olirf_pkg::OP_FIND:
                begin
                    at = locate(cmd.track_id);
                    if (at >= count)
                        r.status = olirf_pkg::ST_NOT_FOUND;
                    else
                    begin
                        r.found_index    = OUT_W'(at);
                        r.found_duration = durs[at];
                        if (cmd.operation == olirf_pkg::OP_REMOVE)
                        begin
                            sum -= longint'(durs[at]);
                            for (int i = at; i + 1 < count; i++)
                            begin
                                ids[i]  = ids[i+1];
                                durs[i] = durs[i+1];
                            end
                            count--;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count    = OUT_W'(count);
            r.total_duration = (sum > longint'(olirf_pkg::TOTAL_MAX)) ?
                               olirf_pkg::TOTAL_MAX : TOT_W'(sum);
            pending.push_back(r);
        endfunction

        // Compare one result beat with the oldest prediction.
        task check_result(olirf_pkg::result_t got);
            olirf_pkg::result_t want;

            if (pending.size() == 0)
            begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.found_index !== want.found_index)
                report($sformatf("found_index got %0d want %0d",
                                 got.found_index, want.found_index));
            if (got.found_duration !== want.found_duration)
                report($sformatf("found_duration got %0d want %0d",
                                 got.found_duration, want.found_duration));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count got %0d want %0d",
                                 got.entry_count, want.entry_count));
            if (got.total_duration !== want.total_duration)
                report($sformatf("total_duration got %0d want %0d",
                                 got.total_duration, want.total_duration));
        endtask
    endclass

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    olirf_pkg::command_t  command = '0;
    logic                 busy;
    logic                 done;
    olirf_pkg::result_t   result;

    list_scoreboard sb = new();

    ordered_list_insert_remove_find DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Every done beat is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // End the run if no beat moves in either direction for too long.
    initial
    begin : watchdog
        int idle;

        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done))
                idle = 0;
            else
                idle++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic olirf_pkg::command_t make_cmd(logic [OP_W-1:0] op,
                                                     logic [ID_W-1:0] id,
                                                     logic [DUR_W-1:0] dur,
                                                     logic [POS_W-1:0] pos);
        olirf_pkg::command_t c;

        c.operation        = op;
        c.track_id         = id;
        c.duration_seconds = dur;
        c.position         = pos;
        return c;
    endfunction

    // Mostly short gaps, a few long ones; none at all in quiet stretches.
    function automatic int pick_gap(bit no_gaps);
        int roll;

        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random command shaped by the phase and by what the list holds now.
    function automatic olirf_pkg::command_t random_command(phase_e phase);
        olirf_pkg::command_t c;
        int                  roll;
        int                  id_roll;

        roll    = $urandom_range(0, 99);
        id_roll = $urandom_range(0, 99);
        c.duration_seconds = DUR_W'($urandom);
        c.position         = POS_W'($urandom);
        case (phase)
            PH_FILL:  c.operation = (roll < 80) ? olirf_pkg::OP_INSERT :
                                    (roll < 88) ? olirf_pkg::OP_FIND :
                                    (roll < 95) ? olirf_pkg::OP_REMOVE : OP_UNUSED;
            PH_DRAIN: c.operation = (roll < 15) ? olirf_pkg::OP_INSERT :
                                    (roll < 30) ? olirf_pkg::OP_FIND :
                                    (roll < 95) ? olirf_pkg::OP_REMOVE : OP_UNUSED;
            default:  c.operation = (roll < 40) ? olirf_pkg::OP_INSERT :
                                    (roll < 65) ? olirf_pkg::OP_FIND :
                                    (roll < 92) ? olirf_pkg::OP_REMOVE : OP_UNUSED;
        endcase

        // Ids: existing ones for hits and duplicates, a small pool, or anything.
        if (sb.count > 0 && id_roll < ((c.operation == olirf_pkg::OP_INSERT) ? 30 : 70))
            c.track_id = sb.ids[$urandom_range(0, sb.count - 1)];
        else if (id_roll < 85)
            c.track_id = ID_W'($urandom_range(0, 15));
        else
            c.track_id = ID_W'($urandom);

        if (c.operation == olirf_pkg::OP_INSERT)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                c.duration_seconds = '0;
            else if (roll < 20)
                c.duration_seconds = '1;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                c.position = POS_W'($urandom_range(0, sb.count + 1));
            else if (roll < 80)
                c.position = POS_W'(sb.count);
            else if (roll < 90)
                c.position = POS_W'($urandom_range(0, 16'h7fff));
        end
        return c;
    endfunction

    // Present one command beat after a gap and wait until it is taken.
    task automatic send_command(olirf_pkg::command_t cmd, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_command(cmd);
    endtask

    initial
    begin : main
        olirf_pkg::command_t directed [$];
        phase_e              phase;
        int                  phase_len;
        int                  sent;
        bit                  no_gaps;
        olirf_pkg::command_t cmd;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed run: empty list, extremes of each field, duplicates,
        // both ends and the middle, misses and the unused code.
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'h0000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h8000_0000, 20'hfffff, 16'hffff));
        directed.push_back(make_cmd(OP_UNUSED,            32'hffff_ffff, 20'hfffff, 16'hffff));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h8000_0000, 20'h00000, 16'h8000));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h8000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h7fff_ffff, 20'hfffff, 16'h7fff));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h0000_0000, 20'h00001, 16'h0001));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h0000_0000, 20'h00005, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'hffff_ffff, 20'h12345, 16'h0004));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'h1234_5678, 20'h54321, 16'hffff));
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'h0000_0000, 20'hfffff, 16'h8000));
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'h7fff_ffff, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'hffff_ffff, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'h0001_2345, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h0000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_FIND,   32'h0000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'hffff_ffff, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h8000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h5555_5555, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(OP_UNUSED,            32'h0f0f_0f0f, 20'h0aaaa, 16'h1234));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h0000_0000, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_REMOVE, 32'h7fff_ffff, 20'h00000, 16'h0000));
        directed.push_back(make_cmd(olirf_pkg::OP_INSERT, 32'haaaa_5555, 20'hfffff, 16'h7fff));
        foreach (directed[i])
            send_command(directed[i], pick_gap(1'b0));

        // Random phases: fill toward full, drain toward empty, or churn.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase     = phase_e'($urandom_range(0, 2));
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_len = (phase == PH_FILL)  ? 150 :
                        (phase == PH_DRAIN) ? 130 : $urandom_range(30, 120);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                cmd = random_command(phase);
                send_command(cmd, pick_gap(no_gaps));
                if (cmd.operation != OP_UNUSED)
                    sent++;
            end
        end
        start <= 1'b0;

        // Let every predicted beat arrive, then watch for strays.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/olirf_pkg.sv
rtl/olirf_ram.sv
rtl/olirf_seq.sv
rtl/ordered_list_insert_remove_find.sv
tb/sv/tb.sv
